FILE: hdl/sfcrd_pkg.sv
`default_nettype none
package sfcrd_pkg;

   localparam int NUM_STEPS = 6;
   localparam int STEP_W    = $clog2(NUM_STEPS);
   localparam int TBL_W     = 4;
   localparam int TBL_DEPTH = 1 << TBL_W;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   localparam logic [7:0] STEP_THR [0:TBL_DEPTH-1] = '{
      8'd0,  8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66,
      8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74
   };

   localparam logic [6:0] STEP_DUTY [0:TBL_DEPTH-1] = '{
      7'd50,  7'd60,  7'd70,  7'd80,  7'd90,  7'd100, 7'd100, 7'd100,
      7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
   };

   localparam logic [1:0] CSR_DOWN_HYST = 2'd0;
   localparam logic [1:0] CSR_WINDOW    = 2'd1;
   localparam logic [1:0] CSR_CONFIRM   = 2'd2;

   localparam logic COMMAND_POLL = 1'b0;
   localparam logic COMMAND_TICK = 1'b1;

   typedef struct packed {
      logic [7:0]       value;
      logic             use_hyst;
      logic [TBL_W-1:0] index;
   } cmp_req_type;

endpackage
`default_nettype wire

FILE: hdl/sfcrd_if.sv
`default_nettype none
interface sfcrd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] temperature;
   logic [7:0] confirm_temperature;
   logic       system_active;

   modport source (output valid, command, temperature, confirm_temperature, system_active,
                   input ready);
   modport sink (input valid, command, temperature, confirm_temperature, system_active,
                 output ready);
endinterface

interface sfcrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] duty_pct;
   logic       fan_power;
   logic [2:0] step_index;
   logic       window_pending;

   modport source (output valid, duty_pct, fan_power, step_index, window_pending,
                   input ready);
   modport sink (input valid, duty_pct, fan_power, step_index, window_pending,
                 output ready);
endinterface

interface sfcrd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/stepped_fan_curve_rampdown_delay.sv
`default_nettype none
// Stepped fan curve controller. Temperature polls move a step index through the
// first six entries of a 16-entry threshold/duty table; ramp-up is immediate
// (optionally confirmed by a second reading), ramp-down waits for a window
// counted down by tick items. Each item gives one response carrying the duty,
// fan power, step and window state after that item. Items are handled one at a
// time on a single shared threshold comparator, one compare per cycle: a tick
// or inactive poll goes straight to its response, and an active poll makes more
// compares the more steps it walks up or down; a ramp-down through the whole
// table is the longest case.
// The response is held until taken, during which no new item is accepted.
// Configuration writes are taken at any time and must be issued while idle.
module stepped_fan_curve_rampdown_delay (
   input wire logic    clock,
   input wire logic    reset,
   sfcrd_req_if.sink   req_if,
   sfcrd_rsp_if.source rsp_if,
   sfcrd_csr_if.sink   csr_if
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CONF  = 8'b0000_0010,
      S_CONF2 = 8'b0000_0100,
      S_TOP   = 8'b0000_1000,
      S_UP    = 8'b0001_0000,
      S_LOW   = 8'b0010_0000,
      S_DOWN  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type                        state_ff, state_in;
   logic [sfcrd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                             armed_ff, armed_in;
   logic [15:0]                      rem_ff, rem_in;
   logic                             fan_ff, fan_in;
   logic                             raised_ff, raised_in;
   logic [7:0]                       temp_ff, temp_in;
   logic [7:0]                       temp2_ff;
   logic [3:0]                       hyst_ff;
   logic [15:0]                      wticks_ff;
   logic                             confirm_ff;

   sfcrd_pkg::cmp_req_type           cmp_req;
   logic                             below;
   logic [sfcrd_pkg::TBL_W-1:0]      step_tbl;
   logic [sfcrd_pkg::TBL_W-1:0]      next_tbl;
   logic                             not_top;
   logic                             is_low;
   logic                             req_fire;

   assign step_tbl = sfcrd_pkg::TBL_W'(step_ff);
   assign next_tbl = step_tbl + sfcrd_pkg::TBL_W'(1);
   assign not_top  = step_ff < sfcrd_pkg::LAST_STEP;
   assign is_low   = (step_ff != '0) && below;
   assign req_fire = req_if.valid && req_if.ready;

   sfcrd_cmp_unit u_cmp (
      .cmp_req   (cmp_req),
      .down_hyst (hyst_ff),
      .below     (below)
   );

   always_comb begin
      cmp_req.value    = temp_ff;
      cmp_req.use_hyst = 1'b0;
      cmp_req.index    = next_tbl;
      case (state_ff)
         S_CONF2: begin
            cmp_req.value = temp2_ff;
         end
         S_TOP: begin
            cmp_req.index = sfcrd_pkg::TBL_W'(sfcrd_pkg::LAST_STEP);
         end
         S_LOW, S_DOWN: begin
            cmp_req.use_hyst = 1'b1;
            cmp_req.index    = step_tbl;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      armed_in  = armed_ff;
      rem_in    = rem_ff;
      fan_in    = fan_ff;
      raised_in = raised_ff;
      temp_in   = temp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               temp_in   = req_if.temperature;
               raised_in = 1'b0;
               if (req_if.command == sfcrd_pkg::COMMAND_TICK) begin
                  if (armed_ff && rem_ff != 16'd0) begin
                     rem_in = rem_ff - 16'd1;
                  end
                  state_in = S_OUT;
               end else if (!req_if.system_active) begin
                  fan_in   = 1'b0;
                  state_in = S_OUT;
               end else begin
                  fan_in   = 1'b1;
                  state_in = S_CONF;
               end
            end
         end
         S_CONF: begin
            if (confirm_ff && not_top && !below) begin
               state_in = S_CONF2;
            end else begin
               state_in = S_TOP;
            end
         end
         S_CONF2: begin
            if (!below) begin
               temp_in  = temp2_ff;
               state_in = S_TOP;
            end else begin
               state_in = S_OUT;
            end
         end
         S_TOP: begin
            if (!below) begin
               step_in  = sfcrd_pkg::LAST_STEP;
               armed_in = 1'b0;
               rem_in   = 16'd0;
               state_in = S_OUT;
            end else begin
               state_in = S_UP;
            end
         end
         S_UP: begin
            if (not_top && !below) begin
               step_in   = step_ff + sfcrd_pkg::STEP_W'(1);
               raised_in = 1'b1;
            end else if (raised_ff) begin
               armed_in = 1'b0;
               rem_in   = 16'd0;
               state_in = S_OUT;
            end else begin
               state_in = S_LOW;
            end
         end
         S_LOW: begin
            if (is_low) begin
               if (!armed_ff) begin
                  armed_in = 1'b1;
                  rem_in   = wticks_ff;
                  state_in = S_OUT;
               end else if (rem_ff != 16'd0) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_DOWN;
               end
            end else begin
               armed_in = 1'b0;
               rem_in   = 16'd0;
               state_in = S_OUT;
            end
         end
         S_DOWN: begin
            if (is_low) begin
               step_in = step_ff - sfcrd_pkg::STEP_W'(1);
            end else begin
               armed_in = 1'b0;
               rem_in   = 16'd0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         step_ff    <= '0;
         armed_ff   <= 1'b0;
         rem_ff     <= 16'd0;
         fan_ff     <= 1'b0;
         raised_ff  <= 1'b0;
         hyst_ff    <= 4'd0;
         wticks_ff  <= 16'd60;
         confirm_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         armed_ff  <= armed_in;
         rem_ff    <= rem_in;
         fan_ff    <= fan_in;
         raised_ff <= raised_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               sfcrd_pkg::CSR_DOWN_HYST: hyst_ff    <= csr_if.data[3:0];
               sfcrd_pkg::CSR_WINDOW:    wticks_ff  <= csr_if.data;
               sfcrd_pkg::CSR_CONFIRM:   confirm_ff <= csr_if.data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
      if (req_fire) begin
         temp2_ff <= req_if.confirm_temperature;
      end
   end

   assign req_if.ready          = (state_ff == S_IDLE);
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = (state_ff == S_OUT);
   assign rsp_if.duty_pct       = sfcrd_pkg::STEP_DUTY[step_tbl];
   assign rsp_if.fan_power      = fan_ff;
   assign rsp_if.step_index     = step_tbl[2:0];
   assign rsp_if.window_pending = armed_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= sfcrd_pkg::LAST_STEP)
      else $error("step index past last table entry");

   a_window_idle: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> rem_ff == 16'd0)
      else $error("window count nonzero while no window armed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("new item taken while response pending");

   a_return_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready |=> req_if.ready)
      else $error("not ready after response taken");

endmodule
`default_nettype wire

FILE: hdl/sfcrd_cmp_unit.sv
`default_nettype none
module sfcrd_cmp_unit (
   input  wire sfcrd_pkg::cmp_req_type cmp_req,
   input  wire logic [3:0]             down_hyst,
   output logic                        below
);

   logic [8:0] lhs;
   logic [8:0] rhs;

   // value (+ hysteresis) < threshold of the selected step
   assign lhs   = {1'b0, cmp_req.value} + (cmp_req.use_hyst ? {5'b0, down_hyst} : 9'd0);
   assign rhs   = {1'b0, sfcrd_pkg::STEP_THR[cmp_req.index]};
   assign below = lhs < rhs;

endmodule
`default_nettype wire
